// ===== hw/rtl/sm3_hash_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Implication macros used by the engine's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_TOP_MACROS_SVH
`define SM3_HASH_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// SM3 package
// Initial value, round constants and bit helpers for the SM3 engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned WordCount = 8;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds = 64;

   localparam word_type Iv [WordCount] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   localparam word_type TLow  = 32'h79CC4519;
   localparam word_type THigh = 32'h7A879D8A;
   localparam logic [7:0] PadByte = 8'h80;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic word_type perm0(input word_type x);
      perm0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      perm1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ===== hw/rtl/sm3_hash_engine_top.sv =====
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-serial SM3 hash with a 16-word block memory and a one-round-per-cycle
// compression core; emits the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// request   req_data_byte, req_has_byte, req_last   start & !busy
// response  rsp_digest_word, rsp_last_word          rsp_valid, one cycle
//
// A plain byte is packed into the current word. The 64th byte of a block
// loads the block memory into the expansion window, runs 64 rounds and
// folds. A last word adds up to 18 padding writes, one or two compressions
// and the eight digest words. Reset is synchronous and loads the IV; the
// block memory is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_has_byte,
   input  logic                 req_last,
   output logic                 rsp_valid,
   output sm3_pkg::word_type    rsp_digest_word,
   output logic                 rsp_last_word
);
   import sm3_pkg::*;

   `include "sm3_hash_engine_top_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      POST_IDLE, POST_PADIN, POST_PAD2, POST_FINAL
   } post_type;

   state_type   state_ff, state_in;
   post_type    post_ff, post_in;
   logic [60:0] total_ff, total_in;
   word_type    cur_ff, cur_in;
   logic [3:0]  pad_ff, pad_in;
   logic        first_ff, first_in;
   logic        lenok_ff, lenok_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_ff, out_in;
   word_type    ch_ff [WordCount];
   word_type    ch_in [WordCount];
   word_type    rr_ff [WordCount];
   word_type    rr_in [WordCount];
   word_type    win_ff [BlockWords];
   word_type    win_in [BlockWords];
   logic        rv_ff, rv_in;
   word_type    rw_ff, rw_in;
   logic        rl_ff, rl_in;

   // block memory
   word_type    mem [BlockWords];
   logic        we;
   logic [3:0]  waddr;
   word_type    wdata;
   word_type    rdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[cnt_ff[3:0]];
   end

   // round datapath
   word_type tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, wj, wpj, wnext;
   logic [5:0] pos;
   logic [1:0] lane;
   word_type   byte_word, merged, lenval;

   assign pos  = total_ff[5:0];
   assign lane = pos[1:0];

   always_comb begin
      tj  = (round_ff < 6'd16) ? TLow : THigh;
      wj  = win_ff[0];
      wpj = win_ff[0] ^ win_ff[4];
      a12 = rotl(rr_ff[0], 5'd12);
      ss1 = rotl(a12 + rr_ff[4] + rotl(tj, round_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ffv = rr_ff[0] ^ rr_ff[1] ^ rr_ff[2];
         ggv = rr_ff[4] ^ rr_ff[5] ^ rr_ff[6];
      end else begin
         ffv = (rr_ff[0] & rr_ff[1]) | (rr_ff[0] & rr_ff[2]) | (rr_ff[1] & rr_ff[2]);
         ggv = (rr_ff[4] & rr_ff[5]) | (~rr_ff[4] & rr_ff[6]);
      end
      tt1 = ffv + rr_ff[3] + ss2 + wpj;
      tt2 = ggv + rr_ff[7] + ss1 + wj;
      wnext = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
            ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
      byte_word = {24'd0, req_data_byte} << (5'd24 - {lane, 3'd0});
      merged = ((lane == 2'd0) ? 32'd0 : cur_ff)
             | ({24'd0, PadByte} << (5'd24 - {lane, 3'd0}));
      if (lenok_ff && pad_ff == 4'd14) begin
         lenval = total_ff[60:29];
      end else if (lenok_ff && pad_ff == 4'd15) begin
         lenval = {total_ff[28:0], 3'd0};
      end else begin
         lenval = 32'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      post_in  = post_ff;
      total_in = total_ff;
      cur_in   = cur_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      lenok_in = lenok_ff;
      cnt_in   = cnt_ff;
      round_in = round_ff;
      out_in   = out_ff;
      ch_in    = ch_ff;
      rr_in    = rr_ff;
      win_in   = win_ff;
      rv_in    = 1'b0;
      rw_in    = rw_ff;
      rl_in    = 1'b0;
      we       = 1'b0;
      waddr    = pad_ff;
      wdata    = first_ff ? merged : lenval;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_has_byte) begin
                  cur_in   = ((lane == 2'd0) ? 32'd0 : cur_ff) | byte_word;
                  total_in = total_ff + 61'd1;
                  if (lane == 2'd3) begin
                     we    = 1'b1;
                     waddr = pos[5:2];
                     wdata = cur_in;
                  end
               end
               if (req_has_byte && pos == 6'd63) begin
                  state_in = ST_LOAD;
                  cnt_in   = 5'd0;
                  post_in  = req_last ? POST_PADIN : POST_IDLE;
               end else if (req_last) begin
                  state_in = ST_PAD;
                  pad_in   = total_in[5:2];
                  first_in = 1'b1;
                  lenok_in = (total_in[5:3] != 3'd7);
               end
            end
         end
         ST_PAD: begin
            we       = 1'b1;
            first_in = 1'b0;
            pad_in   = pad_ff + 4'd1;
            if (pad_ff == 4'd15) begin
               state_in = ST_LOAD;
               cnt_in   = 5'd0;
               post_in  = lenok_ff ? POST_FINAL : POST_PAD2;
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff != 5'd0) begin
               for (int k = 0; k < BlockWords - 1; k++) begin
                  win_in[k] = win_ff[k + 1];
               end
               win_in[BlockWords - 1] = rdata;
            end
            if (cnt_ff == 5'd16) begin
               state_in = ST_ROUND;
               round_in = 6'd0;
               rr_in    = ch_ff;
            end
         end
         ST_ROUND: begin
            rr_in[0] = tt1;
            rr_in[1] = rr_ff[0];
            rr_in[2] = rotl(rr_ff[1], 5'd9);
            rr_in[3] = rr_ff[2];
            rr_in[4] = perm0(tt2);
            rr_in[5] = rr_ff[4];
            rr_in[6] = rotl(rr_ff[5], 5'd19);
            rr_in[7] = rr_ff[6];
            for (int k = 0; k < BlockWords - 1; k++) begin
               win_in[k] = win_ff[k + 1];
            end
            win_in[BlockWords - 1] = wnext;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(Rounds - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int k = 0; k < WordCount; k++) begin
               ch_in[k] = ch_ff[k] ^ rr_ff[k];
            end
            case (post_ff)
               POST_IDLE: state_in = ST_IDLE;
               POST_PADIN: begin
                  state_in = ST_PAD;
                  pad_in   = 4'd0;
                  first_in = 1'b1;
                  lenok_in = 1'b1;
               end
               POST_PAD2: begin
                  state_in = ST_PAD;
                  pad_in   = 4'd0;
                  first_in = 1'b0;
                  lenok_in = 1'b1;
               end
               POST_FINAL: begin
                  state_in = ST_OUT;
                  out_in   = 3'd0;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            rv_in  = 1'b1;
            rw_in  = ch_ff[out_ff];
            rl_in  = (out_ff == 3'd7);
            out_in = out_ff + 3'd1;
            if (out_ff == 3'd7) begin
               state_in = ST_IDLE;
               ch_in    = Iv;
               total_in = 61'd0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         post_ff  <= POST_IDLE;
         total_ff <= 61'd0;
         ch_ff    <= Iv;
         rv_ff    <= 1'b0;
         rl_ff    <= 1'b0;
         pad_ff   <= 4'd0;
         first_ff <= 1'b0;
         lenok_ff <= 1'b0;
         cnt_ff   <= 5'd0;
         round_ff <= 6'd0;
         out_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
         total_ff <= total_in;
         ch_ff    <= ch_in;
         rv_ff    <= rv_in;
         rl_ff    <= rl_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         lenok_ff <= lenok_in;
         cnt_ff   <= cnt_in;
         round_ff <= round_in;
         out_ff   <= out_in;
      end
      cur_ff <= cur_in;
      rr_ff  <= rr_in;
      win_ff <= win_in;
      rw_ff  <= rw_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rv_ff;
   assign rsp_digest_word = rw_ff;
   assign rsp_last_word   = rl_ff;

   `SM3_ASSERT_IMPL(a_last_has_valid, clock, reset, rl_ff, rv_ff)
   `SM3_ASSERT_IMPL(a_round_in_range, clock, reset, state_ff == ST_LOAD, cnt_ff <= 5'd16)
   `SM3_ASSERT_IMPL(a_last_ends_msg, clock, reset, rl_ff, total_ff == 61'd0)
   `SM3_ASSERT_NEXT(a_out_streams, clock, reset,
      state_ff == ST_OUT && out_ff != 3'd7, state_ff == ST_OUT)
endmodule

// ===== tb/sv/sm3_hash_engine_checker.sv =====
// ----------------------------------------------------------------------------
// SM3 hash engine checker
// Watches accepted request words, keeps its own SM3 state, queues the
// expected digest words and compares every response word against them.
// ----------------------------------------------------------------------------
module sm3_hash_engine_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [7:0]        req_data_byte,
   input  logic              req_has_byte,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  sm3_pkg::word_type rsp_digest_word,
   input  logic              rsp_last_word,
   output int                fail_count,
   output int                pending_words
);
   import sm3_pkg::*;

   typedef struct packed {
      word_type digest;
      logic     last_word;
   } digest_entry_type;

   word_type         chain [WordCount];
   word_type         msg_block [BlockWords];
   logic [60:0]      byte_count;
   digest_entry_type digest_queue [$];

   assign pending_words = digest_queue.size();

   function automatic word_type rol32(word_type x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic word_type p0_fn(word_type x);
      return x ^ rol32(x, 9) ^ rol32(x, 17);
   endfunction

   function automatic word_type p1_fn(word_type x);
      return x ^ rol32(x, 15) ^ rol32(x, 23);
   endfunction

   task automatic compress_block();
      word_type w [68];
      word_type r [8];
      word_type a12, ss1, ss2, ff, gg, tt1, tt2, tj;
      for (int k = 0; k < 16; k++) w[k] = msg_block[k];
      for (int k = 16; k < 68; k++)
         w[k] = p1_fn(w[k-16] ^ w[k-9] ^ rol32(w[k-3], 15)) ^ rol32(w[k-13], 7) ^ w[k-6];
      for (int k = 0; k < 8; k++) r[k] = chain[k];
      for (int j = 0; j < 64; j++) begin
         tj  = (j < 16) ? TLow : THigh;
         a12 = rol32(r[0], 12);
         ss1 = rol32(a12 + r[4] + rol32(tj, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (r[0] ^ r[1] ^ r[2]) : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
         gg  = (j < 16) ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
         tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + r[7] + ss1 + w[j];
         r[3] = r[2]; r[2] = rol32(r[1], 9); r[1] = r[0]; r[0] = tt1;
         r[7] = r[6]; r[6] = rol32(r[5], 19); r[5] = r[4]; r[4] = p0_fn(tt2);
      end
      for (int k = 0; k < 8; k++) chain[k] ^= r[k];
   endtask

   task automatic place_byte(int pos, logic [7:0] v);
      int wi;
      int lane;
      wi = pos / 4;
      lane = pos % 4;
      if (lane == 0) msg_block[wi] = '0;
      msg_block[wi][31 - 8*lane -: 8] = v;
   endtask

   task automatic absorb_word(logic [7:0] data, logic has, logic fin);
      int pos;
      logic [63:0] bit_len;
      if (has) begin
         pos = byte_count[5:0];
         place_byte(pos, data);
         byte_count = byte_count + 1;
         if (pos == 63) compress_block();
      end
      if (!fin) return;
      pos = byte_count[5:0];
      bit_len = {byte_count, 3'b000};
      place_byte(pos, PadByte);
      for (int k = pos / 4 + 1; k < 16; k++) msg_block[k] = '0;
      if (pos >= 56) begin
         compress_block();
         for (int k = 0; k < 16; k++) msg_block[k] = '0;
      end
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      compress_block();
      for (int k = 0; k < 8; k++) digest_queue.push_back('{chain[k], k == 7});
      for (int k = 0; k < 8; k++) chain[k] = Iv[k];
      byte_count = '0;
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      digest_entry_type exp_word;
      if (reset) begin
         for (int k = 0; k < 8; k++) chain[k] = Iv[k];
         byte_count = '0;
         digest_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h", rsp_digest_word));
            end else begin
               exp_word = digest_queue.pop_front();
               if (rsp_digest_word !== exp_word.digest)
                  report_mismatch($sformatf("digest word %h, expected %h",
                     rsp_digest_word, exp_word.digest));
               if (rsp_last_word !== exp_word.last_word)
                  report_mismatch($sformatf("last_word %b, expected %b",
                     rsp_last_word, exp_word.last_word));
            end
         end
         if (start && !busy) absorb_word(req_data_byte, req_has_byte, req_last);
      end
   end
endmodule

// ===== tb/sv/sm3_hash_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Feeds directed and random byte messages with random start gaps; the
// checker predicts each digest and reports the verdict count.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top_tb;
   import sm3_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [7:0]        req_data_byte = '0;
   logic              req_has_byte = 1'b0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   word_type          rsp_digest_word;
   logic              rsp_last_word;
   int                fail_count;
   int                pending_words;
   int                words_sent;
   bit                allow_gaps;

   always #10 clock = ~clock;

   sm3_hash_engine_top dut (.*);

   sm3_hash_engine_checker checker_i (.*);

   // hold start high until the word is taken
   task automatic send_word(logic [7:0] data, logic has, logic fin);
      int gap;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data_byte <= data;
      req_has_byte <= has;
      req_last <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   task automatic run_message(int len);
      bit closed;
      closed = 0;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         if (k == len - 1 && $urandom_range(0, 1)) begin
            send_word(8'($urandom), 1'b1, 1'b1);
            closed = 1;
         end else begin
            send_word(8'($urandom), 1'b1, 1'b0);
         end
      end
      if (!closed) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      int lens [8];
      int len;
      allow_gaps = 1'b1;
      words_sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // empty message, then "abc", then a message of an all-ones and an all-zero byte
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h00, 1'b1, 1'b1);
      // padding boundaries: 55, 56, 63, 64 byte messages, then 1, 0, 57 and 3 bytes
      lens = '{55, 56, 63, 64, 1, 0, 57, 3};
      for (int m = 0; m < 8; m++) run_message(lens[m]);
      while (words_sent < 430) begin
         if (words_sent > 360) allow_gaps = 1'b0;
         len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(50, 70))
                                           : int'($urandom_range(0, 20));
         if (len > 430 - words_sent) len = 430 - words_sent;
         run_message(len);
      end
      start <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
